// ----- sv/circle_from_three_points_core_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef CIRCLE_FROM_THREE_POINTS_CORE_MACROS_SVH
`define CIRCLE_FROM_THREE_POINTS_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CFTP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cftp assertion failed");
`define CFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cftp assertion failed");
`else
`define CFTP_ASSERT(label, clk, rst_n, ante, cons)
`define CFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/cftp_pkg.sv -----
package cftp_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int OUT_FRAC_BITS_DEF   = 8;

    // quotient bits kept by the dividers, equal to the result width
    localparam int Q_BITS = 32;
    localparam int RES_W  = 32;

    localparam logic [RES_W-1:0] POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] NEG_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RAD_MAX = {RES_W{1'b1}};

    typedef struct packed {
        logic [Q_BITS-1:0] q;
        logic              ovf;
        logic              neg;
        logic              dz;
    } div_res_t;

    typedef struct packed {
        logic [RES_W-1:0] center_x;
        logic [RES_W-1:0] center_y;
        logic [RES_W-1:0] radius;
        logic             collinear;
        logic             clipped;
    } result_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // width of the determinant and of the squared lengths
    function automatic int det_w(input int w);
        return 2 * w + 2;
    endfunction

    // width of the centre numerators
    function automatic int num_w(input int w);
        return 3 * w + 4;
    endfunction

endpackage

// ----- sv/cftp_front.sv -----
module cftp_front #(
    parameter int COORD_WIDTH = cftp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              adv,
    input  logic                                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]                     first_x,
    input  logic signed [COORD_WIDTH-1:0]                     first_y,
    input  logic signed [COORD_WIDTH-1:0]                     second_x,
    input  logic signed [COORD_WIDTH-1:0]                     second_y,
    input  logic signed [COORD_WIDTH-1:0]                     third_x,
    input  logic signed [COORD_WIDTH-1:0]                     third_y,
    output logic                                              out_valid,
    output logic [cftp_pkg::num_w(COORD_WIDTH)-1:0]           cx,
    output logic [cftp_pkg::num_w(COORD_WIDTH)-1:0]           cy,
    output logic [cftp_pkg::num_w(COORD_WIDTH)-1:0]           nx,
    output logic [cftp_pkg::num_w(COORD_WIDTH)-1:0]           ny,
    output logic [cftp_pkg::det_w(COORD_WIDTH)-1:0]           det
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int SW  = cftp_pkg::det_w(W);
    localparam int NW  = cftp_pkg::num_w(W);
    localparam int L   = W + 1;
    localparam int HW  = SW - L;
    localparam int PLW = L + 1 + DW;
    localparam int PHW = HW + DW;

    logic [5:0] v_reg;

    // stage 1: offsets from the first point
    logic signed [W-1:0]  x1_1_reg, y1_1_reg;
    logic signed [DW-1:0] ux_1_reg, uy_1_reg, vx_1_reg, vy_1_reg;
    // stage 2: squares and cross products
    logic signed [W-1:0]  x1_2_reg, y1_2_reg;
    logic signed [DW-1:0] ux_2_reg, uy_2_reg, vx_2_reg, vy_2_reg;
    logic signed [SW-1:0] qux_reg, quy_reg, qvx_reg, qvy_reg, p1_reg, p2_reg;
    // stage 3: squared lengths and determinant
    logic signed [W-1:0]  x1_3_reg, y1_3_reg;
    logic signed [DW-1:0] ux_3_reg, uy_3_reg, vx_3_reg, vy_3_reg;
    logic signed [SW-1:0] su_reg, sv_reg, det_3_reg;
    // stage 4: split partial products, stage 5: full products
    logic signed [PLW-1:0] pl_reg [6];
    logic signed [PHW-1:0] ph_reg [6];
    logic [NW-1:0]         prod_reg [6];
    logic [SW-1:0]         det_4_reg, det_5_reg, det_6_reg;
    // stage 6: numerators
    logic [NW-1:0]         cx_reg, cy_reg, nx_reg, ny_reg;

    logic signed [SW-1:0]  a_op [6];
    logic signed [DW-1:0]  b_op [6];
    logic signed [PLW-1:0] pl_next [6];
    logic signed [PHW-1:0] ph_next [6];
    logic [NW-1:0]         prod_next [6];

    always_comb
    begin
        a_op[0] = su_reg;    b_op[0] = vy_3_reg;
        a_op[1] = sv_reg;    b_op[1] = uy_3_reg;
        a_op[2] = sv_reg;    b_op[2] = ux_3_reg;
        a_op[3] = su_reg;    b_op[3] = vx_3_reg;
        a_op[4] = det_3_reg; b_op[4] = $signed({x1_3_reg[W-1], x1_3_reg});
        a_op[5] = det_3_reg; b_op[5] = $signed({y1_3_reg[W-1], y1_3_reg});
        for (int k = 0; k < 6; k++)
        begin
            pl_next[k] = $signed({1'b0, a_op[k][L-1:0]}) * b_op[k];
            ph_next[k] = $signed(a_op[k][SW-1:L]) * b_op[k];
            prod_next[k] = ({{(NW-PHW){ph_reg[k][PHW-1]}}, ph_reg[k]} << L)
                         + {{(NW-PLW){pl_reg[k][PLW-1]}}, pl_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_1_reg <= first_x;
            y1_1_reg <= first_y;
            ux_1_reg <= $signed({second_x[W-1], second_x}) - $signed({first_x[W-1], first_x});
            uy_1_reg <= $signed({second_y[W-1], second_y}) - $signed({first_y[W-1], first_y});
            vx_1_reg <= $signed({third_x[W-1], third_x}) - $signed({first_x[W-1], first_x});
            vy_1_reg <= $signed({third_y[W-1], third_y}) - $signed({first_y[W-1], first_y});

            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            ux_2_reg <= ux_1_reg;
            uy_2_reg <= uy_1_reg;
            vx_2_reg <= vx_1_reg;
            vy_2_reg <= vy_1_reg;
            qux_reg  <= ux_1_reg * ux_1_reg;
            quy_reg  <= uy_1_reg * uy_1_reg;
            qvx_reg  <= vx_1_reg * vx_1_reg;
            qvy_reg  <= vy_1_reg * vy_1_reg;
            p1_reg   <= ux_1_reg * vy_1_reg;
            p2_reg   <= uy_1_reg * vx_1_reg;

            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            ux_3_reg  <= ux_2_reg;
            uy_3_reg  <= uy_2_reg;
            vx_3_reg  <= vx_2_reg;
            vy_3_reg  <= vy_2_reg;
            su_reg    <= qux_reg + quy_reg;
            sv_reg    <= qvx_reg + qvy_reg;
            det_3_reg <= p1_reg - p2_reg;

            for (int k = 0; k < 6; k++)
            begin
                pl_reg[k]   <= pl_next[k];
                ph_reg[k]   <= ph_next[k];
                prod_reg[k] <= prod_next[k];
            end
            det_4_reg <= det_3_reg;
            det_5_reg <= det_4_reg;
            det_6_reg <= det_5_reg;

            nx_reg <= prod_reg[0] - prod_reg[1];
            ny_reg <= prod_reg[2] - prod_reg[3];
            cx_reg <= (prod_reg[4] << 1) + prod_reg[0] - prod_reg[1];
            cy_reg <= (prod_reg[5] << 1) + prod_reg[2] - prod_reg[3];
        end
    end

    assign out_valid = v_reg[5];
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign det       = det_6_reg;

endmodule

// ----- sv/cftp_div.sv -----
// rounded quotient |num| * 2^OF / (2 * |den| * 2^CF), one quotient bit per stage
module cftp_div #(
    parameter int NUMW = cftp_pkg::num_w(cftp_pkg::COORD_WIDTH_DEF),
    parameter int DENW = cftp_pkg::det_w(cftp_pkg::COORD_WIDTH_DEF),
    parameter int CF   = cftp_pkg::COORD_FRAC_BITS_DEF,
    parameter int OF   = cftp_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [NUMW-1:0]     num,
    input  logic [DENW-1:0]     den,
    output logic                out_valid,
    output cftp_pkg::div_res_t  res
);

    localparam int QB  = cftp_pkg::Q_BITS;
    localparam int MDW = DENW + CF + 1;
    localparam int NNW = cftp_pkg::max2(NUMW + OF, DENW + CF) + 1;
    localparam int CW  = cftp_pkg::max2(NNW, MDW + QB);

    // stage a: magnitudes and sign
    logic              va_reg, nega_reg, dza_reg;
    logic [NUMW-1:0]   an_reg;
    logic [DENW-1:0]   ad_reg;
    // stage b: rounding offset added
    logic              vb_reg, negb_reg, dzb_reg;
    logic [NNW-1:0]    n_reg;
    logic [MDW-1:0]    mdb_reg;
    // stage c and the bit steps
    logic              v_reg   [QB+1];
    logic              neg_reg [QB+1];
    logic              dz_reg  [QB+1];
    logic              ovf_reg [QB+1];
    logic [CW-1:0]     r_reg   [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic [MDW-1:0]    md_reg  [QB+1];

    logic [CW-1:0]     r_next  [QB];
    logic [QB-1:0]     q_next  [QB];

    always_comb
    begin
        logic [CW-1:0] t;
        for (int k = 0; k < QB; k++)
        begin
            t = CW'(md_reg[k]) << (QB - 1 - k);
            r_next[k] = r_reg[k];
            q_next[k] = q_reg[k];
            if (r_reg[k] >= t)
            begin
                r_next[k] = r_reg[k] - t;
                q_next[k][QB-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            va_reg   <= in_valid;
            vb_reg   <= va_reg;
            v_reg[0] <= vb_reg;
            for (int k = 0; k < QB; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nega_reg <= num[NUMW-1] ^ den[DENW-1];
            dza_reg  <= (den == '0);
            an_reg   <= num[NUMW-1] ? (~num + 1'b1) : num;
            ad_reg   <= den[DENW-1] ? (~den + 1'b1) : den;

            negb_reg <= nega_reg;
            dzb_reg  <= dza_reg;
            n_reg    <= (NNW'(an_reg) << OF) + (NNW'(ad_reg) << CF);
            mdb_reg  <= MDW'(ad_reg) << (CF + 1);

            neg_reg[0] <= negb_reg;
            dz_reg[0]  <= dzb_reg;
            ovf_reg[0] <= CW'(n_reg) >= (CW'(mdb_reg) << QB);
            r_reg[0]   <= CW'(n_reg);
            q_reg[0]   <= '0;
            md_reg[0]  <= mdb_reg;

            for (int k = 0; k < QB; k++)
            begin
                neg_reg[k+1] <= neg_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                r_reg[k+1]   <= r_next[k];
                q_reg[k+1]   <= q_next[k];
                md_reg[k+1]  <= md_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign res.q     = q_reg[QB];
    assign res.ovf   = ovf_reg[QB];
    assign res.neg   = neg_reg[QB];
    assign res.dz    = dz_reg[QB];

endmodule

// ----- sv/cftp_sqrt.sv -----
// radius from the rounded offsets: round(sqrt(ax^2 + ay^2)), one root bit per stage
module cftp_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [cftp_pkg::RES_W-1:0]   ax,
    input  logic [cftp_pkg::RES_W-1:0]   ay,
    input  logic                         big,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [cftp_pkg::RES_W-1:0]   radius,
    output logic                         rclip,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int RW = cftp_pkg::RES_W;
    localparam int SQ = 2 * RW;
    localparam int XW = SQ + 2;

    logic              v1_reg, vo_reg;
    logic              big1_reg, clip_o_reg;
    logic [SQ-1:0]     sx_reg, sy_reg;
    logic [SIDE_W-1:0] side1_reg, side_o_reg;
    logic [RW-1:0]     rad_o_reg;

    logic              v_reg    [RW+1];
    logic              big_reg  [RW+1];
    logic [SIDE_W-1:0] side_reg [RW+1];
    logic [XW-1:0]     rem_reg  [RW+1];
    logic [RW-1:0]     root_reg [RW+1];

    logic [XW-1:0]     rem_next  [RW];
    logic [RW-1:0]     root_next [RW];
    logic [SQ:0]       sum;
    logic [RW:0]       rounded;

    assign sum = {1'b0, sx_reg} + {1'b0, sy_reg};

    always_comb
    begin
        logic [XW-1:0] t;
        int            i;
        for (int k = 0; k < RW; k++)
        begin
            i = RW - 1 - k;
            t = (XW'(root_reg[k]) << (i + 1)) + (XW'(1) << (2 * i));
            rem_next[k]  = rem_reg[k];
            root_next[k] = root_reg[k];
            if (rem_reg[k] >= t)
            begin
                rem_next[k]     = rem_reg[k] - t;
                root_next[k][i] = 1'b1;
            end
        end
        // round to nearest: remainder above the root
        rounded = (rem_reg[RW] > XW'(root_reg[RW])) ? ({1'b0, root_reg[RW]} + 1'b1)
                                                    : {1'b0, root_reg[RW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= RW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg   <= in_valid;
            v_reg[0] <= v1_reg;
            for (int k = 0; k < RW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            vo_reg <= v_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg    <= ax * ax;
            sy_reg    <= ay * ay;
            big1_reg  <= big;
            side1_reg <= side_in;

            big_reg[0]  <= big1_reg | sum[SQ];
            side_reg[0] <= side1_reg;
            rem_reg[0]  <= XW'(sum[SQ-1:0]);
            root_reg[0] <= '0;

            for (int k = 0; k < RW; k++)
            begin
                big_reg[k+1]  <= big_reg[k];
                side_reg[k+1] <= side_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
            end

            clip_o_reg <= big_reg[RW] | rounded[RW];
            rad_o_reg  <= (big_reg[RW] | rounded[RW]) ? cftp_pkg::RAD_MAX : rounded[RW-1:0];
            side_o_reg <= side_reg[RW];
        end
    end

    assign out_valid = vo_reg;
    assign radius    = rad_o_reg;
    assign rclip     = clip_o_reg;
    assign side_out  = side_o_reg;

endmodule

// ----- sv/cftp_skid.sv -----
// output register with one skid entry; the pipeline advances while the skid is empty
module cftp_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cftp_pkg::result_t in_data,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_ready,
    output cftp_pkg::result_t out_data
);

    logic              out_valid_reg, skid_valid_reg;
    cftp_pkg::result_t out_data_reg, skid_data_reg;
    logic              take;

    assign adv  = ~skid_valid_reg;
    assign take = adv & in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg | take;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (take)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/circle_from_three_points_core.sv -----
// circle through three points
// input channel: in_valid/in_ready with the six point coordinates, signed,
// COORD_FRAC_BITS fraction bits. output channel: out_valid/out_ready with the
// centre, radius and the collinear and clipped flags, OUT_FRAC_BITS fraction bits.
// throughput: one transfer per cycle on each side while out_ready stays high.
// an input transfer reaches out_valid through 6 stages of products and
// numerators, 35 in the dividers (3 setup stages and one quotient bit per
// stage over 32 bits), 1 saturation stage, 35 in the square root (2 setup
// stages, one root bit per stage over 32 bits and a rounding stage), and the
// output register.
// a stalled receiver fills the output register and then one skid entry; the
// pipeline freezes as a whole and in_ready drops only while the skid is full.
// reset clears every valid bit; no item is in flight after reset and the
// block takes input as soon as rst_n rises.
// collinear points give zeros with collinear set; saturation sets clipped.
`include "circle_from_three_points_core_macros.svh"

module circle_from_three_points_core #(
    parameter int COORD_WIDTH     = cftp_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = cftp_pkg::COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = cftp_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_WIDTH-1:0]    first_x,
    input  logic signed [COORD_WIDTH-1:0]    first_y,
    input  logic signed [COORD_WIDTH-1:0]    second_x,
    input  logic signed [COORD_WIDTH-1:0]    second_y,
    input  logic signed [COORD_WIDTH-1:0]    third_x,
    input  logic signed [COORD_WIDTH-1:0]    third_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [cftp_pkg::RES_W-1:0] center_x,
    output logic signed [cftp_pkg::RES_W-1:0] center_y,
    output logic [cftp_pkg::RES_W-1:0]       radius,
    output logic                             collinear,
    output logic                             clipped
);

    localparam int NW     = cftp_pkg::num_w(COORD_WIDTH);
    localparam int SW     = cftp_pkg::det_w(COORD_WIDTH);
    localparam int RW     = cftp_pkg::RES_W;
    localparam int SIDE_W = 2 * RW + 2;

    logic              adv;
    logic              f_valid;
    logic [NW-1:0]     f_cx, f_cy, f_nx, f_ny;
    logic [SW-1:0]     f_det;

    logic              dv_cx, dv_cy, dv_nx, dv_ny;
    cftp_pkg::div_res_t d_cx, d_cy, d_nx, d_ny;

    logic              p_valid_reg;
    logic [RW-1:0]     p_cx_reg, p_cy_reg, p_ax_reg, p_ay_reg;
    logic              p_clip_reg, p_big_reg, p_dz_reg;
    logic [RW-1:0]     cx_sat, cy_sat;
    logic              cx_clip, cy_clip;

    logic              s_valid;
    logic [RW-1:0]     s_radius;
    logic              s_rclip;
    logic [SIDE_W-1:0] s_side;

    cftp_pkg::result_t res_in, res_out;

    assign in_ready = adv;

    cftp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .out_valid (f_valid),
        .cx        (f_cx),
        .cy        (f_cy),
        .nx        (f_nx),
        .ny        (f_ny),
        .det       (f_det)
    );

    cftp_div #(.NUMW(NW), .DENW(SW), .CF(COORD_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_div_cx (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid),
        .num(f_cx), .den(f_det), .out_valid(dv_cx), .res(d_cx)
    );

    cftp_div #(.NUMW(NW), .DENW(SW), .CF(COORD_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_div_cy (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid),
        .num(f_cy), .den(f_det), .out_valid(dv_cy), .res(d_cy)
    );

    cftp_div #(.NUMW(NW), .DENW(SW), .CF(COORD_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_div_nx (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid),
        .num(f_nx), .den(f_det), .out_valid(dv_nx), .res(d_nx)
    );

    cftp_div #(.NUMW(NW), .DENW(SW), .CF(COORD_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_div_ny (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(f_valid),
        .num(f_ny), .den(f_det), .out_valid(dv_ny), .res(d_ny)
    );

    // centre saturation to the signed 32-bit range
    always_comb
    begin
        cx_clip = 1'b0;
        cy_clip = 1'b0;
        priority if (d_cx.ovf || (d_cx.neg && d_cx.q > cftp_pkg::NEG_MIN))
        begin
            cx_sat  = d_cx.neg ? cftp_pkg::NEG_MIN : cftp_pkg::POS_MAX;
            cx_clip = 1'b1;
        end
        else if (d_cx.neg)
        begin
            cx_sat = ~d_cx.q + 1'b1;
        end
        else if (d_cx.q > cftp_pkg::POS_MAX)
        begin
            cx_sat  = cftp_pkg::POS_MAX;
            cx_clip = 1'b1;
        end
        else
        begin
            cx_sat = d_cx.q;
        end

        priority if (d_cy.ovf || (d_cy.neg && d_cy.q > cftp_pkg::NEG_MIN))
        begin
            cy_sat  = d_cy.neg ? cftp_pkg::NEG_MIN : cftp_pkg::POS_MAX;
            cy_clip = 1'b1;
        end
        else if (d_cy.neg)
        begin
            cy_sat = ~d_cy.q + 1'b1;
        end
        else if (d_cy.q > cftp_pkg::POS_MAX)
        begin
            cy_sat  = cftp_pkg::POS_MAX;
            cy_clip = 1'b1;
        end
        else
        begin
            cy_sat = d_cy.q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= dv_cx & dv_cy & dv_nx & dv_ny;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cx_reg   <= cx_sat;
            p_cy_reg   <= cy_sat;
            p_clip_reg <= cx_clip | cy_clip;
            p_ax_reg   <= d_nx.q;
            p_ay_reg   <= d_ny.q;
            p_big_reg  <= d_nx.ovf | d_ny.ovf;
            p_dz_reg   <= d_cx.dz;
        end
    end

    cftp_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid_reg),
        .ax        (p_ax_reg),
        .ay        (p_ay_reg),
        .big       (p_big_reg),
        .side_in   ({p_cx_reg, p_cy_reg, p_clip_reg, p_dz_reg}),
        .out_valid (s_valid),
        .radius    (s_radius),
        .rclip     (s_rclip),
        .side_out  (s_side)
    );

    // collinear points report zeros
    always_comb
    begin
        res_in.collinear = s_side[0];
        if (s_side[0])
        begin
            res_in.center_x = '0;
            res_in.center_y = '0;
            res_in.radius   = '0;
            res_in.clipped  = 1'b0;
        end
        else
        begin
            res_in.center_x = s_side[SIDE_W-1 -: RW];
            res_in.center_y = s_side[2 +: RW];
            res_in.radius   = s_radius;
            res_in.clipped  = s_side[1] | s_rclip;
        end
    end

    cftp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_data   (res_in),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign center_x  = res_out.center_x;
    assign center_y  = res_out.center_y;
    assign radius    = res_out.radius;
    assign collinear = res_out.collinear;
    assign clipped   = res_out.clipped;

    `CFTP_ASSERT(a_div_valid_agree, clk, rst_n, 1'b1,
        dv_cx == dv_cy && dv_cx == dv_nx && dv_cx == dv_ny)
    `CFTP_ASSERT(a_div_dz_agree, clk, rst_n, dv_cx,
        d_cx.dz == d_cy.dz && d_cx.dz == d_nx.dz && d_cx.dz == d_ny.dz)
    `CFTP_ASSERT(a_collinear_zero, clk, rst_n, out_valid && collinear,
        center_x == '0 && center_y == '0 && radius == '0 && !clipped)
    `CFTP_ASSERT(a_stall_only_when_held, clk, rst_n, !in_ready, out_valid)
    `CFTP_ASSERT_NEXT(a_held_result_kept, clk, rst_n, out_valid && !out_ready && !in_ready,
        out_valid && !in_ready)

endmodule
